// ===== design/rpmf_pkg.sv =====
// ---------------------------------------------------------------------------
// rpmf_pkg: shared types and constants
// Register indexes, reset values, request codes and the control structs
// passed from the top into the pull-in stage and the median window.
// ---------------------------------------------------------------------------
package rpmf_pkg;

  localparam int DIST_BITS_DEF = 13;   // default reading width
  localparam int CFG_BITS      = 13;   // widest config register
  localparam int CNT_BITS      = 4;    // repeat counter / confirm count width
  localparam int REG_IDX_BITS  = 2;

  localparam logic [CFG_BITS-1:0] PULL_RESET    = 13'd120;
  localparam logic [CNT_BITS-1:0] CONFIRM_RESET = 4'd3;
  localparam logic [CFG_BITS-1:0] GAP_RESET     = 13'd80;

  // request codes
  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_PULL    = 2'd0,
    REG_CONFIRM = 2'd1,
    REG_GAP     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] pull;
    logic [CNT_BITS-1:0] confirm;
    logic [CFG_BITS-1:0] gap;
  } cfg_t;

  // per-cycle control: step advances the filters, clear restores reset state
  typedef struct packed {
    logic step;
    logic clear;
  } step_t;

endpackage

// ===== design/rpmf_if.sv =====
// ---------------------------------------------------------------------------
// rpmf_if: channel interfaces
// Request, response and config-write channels, valid/ready handshake.
// ---------------------------------------------------------------------------
interface rpmf_req_if #(
  parameter int DIST_BITS = 13
);
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [DIST_BITS-1:0] distance_mm;

  modport source (output valid, func, distance_mm, input ready);
  modport sink   (input valid, func, distance_mm, output ready);
endinterface

interface rpmf_rsp_if #(
  parameter int DIST_BITS = 13
);
  logic                      valid;
  logic                      ready;
  logic signed [DIST_BITS:0] filtered_mm;

  modport source (output valid, filtered_mm, input ready);
  modport sink   (input valid, filtered_mm, output ready);
endinterface

interface rpmf_cfg_if;
  import rpmf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [REG_IDX_BITS-1:0] index;
  logic [CFG_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/rpmf_pull_in.sv =====
// ---------------------------------------------------------------------------
// rpmf_pull_in: far-surface hold stage
// Holds the far reading; a closer reading must repeat near its first
// candidate confirm times before the candidate replaces the held value.
// ---------------------------------------------------------------------------
module rpmf_pull_in #(
  parameter int DIST_BITS = rpmf_pkg::DIST_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rpmf_pkg::step_t           ctl,
  input  rpmf_pkg::cfg_t            cfg,
  input  logic [DIST_BITS-1:0]      reading,
  output logic signed [DIST_BITS:0] stage_out
);
  import rpmf_pkg::*;

  localparam int WB = (DIST_BITS > CFG_BITS) ? DIST_BITS : CFG_BITS;
  localparam int W  = WB + 2;

  // -1 in bit pattern means nothing held / no candidate
  logic signed [DIST_BITS:0] held, held_next;
  logic signed [DIST_BITS:0] cand, cand_next;
  logic [CNT_BITS-1:0]       repeats, repeats_next;

  logic signed [W-1:0] rd_w, held_w, cand_w, pull_w, half_w, diff, absd;
  logic [CNT_BITS-1:0] rep_inc;
  logic                no_read, has_held, no_cand, is_drop, far_off;

  always_comb begin
    rd_w    = {{(W-DIST_BITS){1'b0}}, reading};
    held_w  = {{(W-DIST_BITS-1){held[DIST_BITS]}}, held};
    cand_w  = {{(W-DIST_BITS-1){cand[DIST_BITS]}}, cand};
    pull_w  = {{(W-CFG_BITS){1'b0}}, cfg.pull};
    half_w  = pull_w >>> 1;
    diff    = rd_w - cand_w;
    absd    = diff[W-1] ? -diff : diff;
    no_read  = (reading == '0);
    has_held = !held[DIST_BITS];      // held is never zero
    no_cand  = cand[DIST_BITS];
    is_drop  = rd_w < (held_w - pull_w);
    far_off  = absd > half_w;
    rep_inc  = repeats + CNT_BITS'(1);
  end

  always_comb begin
    held_next    = held;
    cand_next    = cand;
    repeats_next = repeats;
    stage_out    = held;
    if (no_read) begin
      stage_out = has_held ? held : '0;
    end else if (!has_held) begin
      held_next = {1'b0, reading};
      stage_out = {1'b0, reading};
    end else if (is_drop) begin
      if (no_cand || far_off) begin
        cand_next    = {1'b0, reading};
        repeats_next = CNT_BITS'(1);
      end else if (rep_inc >= cfg.confirm) begin
        // confirmed: the first candidate, not this reading, is taken
        held_next    = cand;
        cand_next    = '1;
        repeats_next = '0;
        stage_out    = cand;
      end else begin
        repeats_next = rep_inc;
      end
    end else begin
      cand_next    = '1;
      repeats_next = '0;
      held_next    = {1'b0, reading};
      stage_out    = {1'b0, reading};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      held    <= '1;
      cand    <= '1;
      repeats <= '0;
    end else if (ctl.step) begin
      held    <= held_next;
      cand    <= cand_next;
      repeats <= repeats_next;
    end
  end

endmodule

// ===== design/rpmf_window.sv =====
// ---------------------------------------------------------------------------
// rpmf_window: three-sample median window
// Median of three, gap fill of a missing middle, pass-through until full.
// ---------------------------------------------------------------------------
module rpmf_window #(
  parameter int DIST_BITS = rpmf_pkg::DIST_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rpmf_pkg::step_t           ctl,
  input  logic [rpmf_pkg::CFG_BITS-1:0] gap,
  input  logic signed [DIST_BITS:0] sample,
  output logic signed [DIST_BITS:0] result
);
  import rpmf_pkg::*;

  localparam int WB = (DIST_BITS > CFG_BITS) ? DIST_BITS : CFG_BITS;
  localparam int W  = WB + 2;

  // only two taps are kept: after the shift the oldest sample is the old middle
  logic signed [DIST_BITS:0] mid, newest;
  logic signed [DIST_BITS:0] a, b, c;
  logic signed [W-1:0]       diff, absd, gap_w;
  logic [DIST_BITS:0]        sum;
  logic                      a_pos, b_nneg, c_pos;

  always_comb begin
    a = mid;
    b = newest;
    c = sample;
    a_pos  = !a[DIST_BITS] && (a != '0);
    b_nneg = !b[DIST_BITS];
    c_pos  = !c[DIST_BITS] && (c != '0);
    diff   = {{(W-DIST_BITS-1){a[DIST_BITS]}}, a} - {{(W-DIST_BITS-1){c[DIST_BITS]}}, c};
    absd   = diff[W-1] ? -diff : diff;
    gap_w  = {{(W-CFG_BITS){1'b0}}, gap};
    sum    = {1'b0, a[DIST_BITS-1:0]} + {1'b0, c[DIST_BITS-1:0]};

    result = b;
    if (a_pos && b_nneg && c_pos) begin
      if (b == '0) begin
        if (absd < gap_w) begin
          result = {1'b0, sum[DIST_BITS:1]};
        end
      end else if ((a > b) != (a > c)) begin
        result = a;
      end else if ((b > a) != (b > c)) begin
        result = b;
      end else begin
        result = c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      mid    <= '1;
      newest <= '1;
    end else if (ctl.step) begin
      mid    <= newest;
      newest <= sample;
    end
  end

endmodule

// ===== design/range_pull_in_and_median_filter_top.sv =====
// ---------------------------------------------------------------------------
// range_pull_in_and_median_filter_top: range pull-in and median filter
// Two-stage filter for averaged range readings, one word per cycle unless the response is held.
// ---------------------------------------------------------------------------
// Usage: each request word carries one range reading (zero = no reading) or
// a clear command. A filter word yields exactly one response word, registered,
// on the cycle after it is accepted; a clear word restores every filter state
// to its reset value and yields nothing. Throughput is one word per cycle:
// both stages are short compare/add logic between the filter state registers
// and the response register, so req.ready only drops while a response sits
// in the output register and rsp.ready is low. The config channel is always
// ready; write registers only while the filter has no word in flight. Index
// 0 = pull distance, 1 = confirm count, 2 = gap limit; other indexes are
// ignored.
// ---------------------------------------------------------------------------
module range_pull_in_and_median_filter_top #(
  parameter int DIST_BITS = rpmf_pkg::DIST_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  rpmf_req_if.sink   req,
  rpmf_rsp_if.source rsp,
  rpmf_cfg_if.sink   cfg
);
  import rpmf_pkg::*;

  // config registers
  cfg_t cfg_regs;

  // output register
  logic                      out_valid;
  logic signed [DIST_BITS:0] out_data;

  logic                      accept;
  step_t                     ctl;
  logic signed [DIST_BITS:0] stage1;
  logic signed [DIST_BITS:0] win_result;

  // new word may enter whenever the output register is empty or draining
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign ctl.step  = accept && (req.func == FUNC_FILTER);
  assign ctl.clear = accept && (req.func == FUNC_CLEAR);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.pull    <= PULL_RESET;
      cfg_regs.confirm <= CONFIRM_RESET;
      cfg_regs.gap     <= GAP_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PULL:    cfg_regs.pull    <= cfg.data;
        REG_CONFIRM: cfg_regs.confirm <= cfg.data[CNT_BITS-1:0];
        REG_GAP:     cfg_regs.gap     <= cfg.data;
        default: ;
      endcase
    end
  end

  // stage one: far-surface hold with near pull-in confirmation
  rpmf_pull_in #(
    .DIST_BITS (DIST_BITS)
  ) u_pull_in (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (cfg_regs),
    .reading   (req.distance_mm),
    .stage_out (stage1)
  );

  // stage two: 3-tap median / gap fill
  rpmf_window #(
    .DIST_BITS (DIST_BITS)
  ) u_window (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .gap    (cfg_regs.gap),
    .sample (stage1),
    .result (win_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.step) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      out_data <= win_result;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.filtered_mm = out_data;

  // ---- checks ----
  // a filter word always produces a response on the next cycle
  a_step_gives_word: assert property (@(posedge clk) disable iff (rst)
    ctl.step |=> rsp.valid)
    else $error("filter word produced no response");

  // a clear word into an empty or draining output register leaves it empty
  a_clear_no_word: assert property (@(posedge clk) disable iff (rst)
    (ctl.clear && (!rsp.valid || rsp.ready)) |=> !rsp.valid)
    else $error("clear word produced a response");

  // filtered value is either the not-filled marker or non-negative
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.filtered_mm >= $signed({(DIST_BITS+1){1'b1}})))
    else $error("filtered value below -1");

endmodule
